@@ hdl/pws_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pws_pkg
// Shared constants, codes and widths of the pair wave scheduler.
// ----------------------------------------------------------------------------
package pws_pkg;

    // table geometry: cells and particles per cell are powers of two
    localparam int CELLS              = 64;
    localparam int PARTICLES_PER_CELL = 64;
    localparam int WAVE_LIMIT         = 255;

    localparam int CELL_W   = $clog2(CELLS);
    localparam int PART_W   = $clog2(PARTICLES_PER_CELL);
    localparam int ADDR_W   = CELL_W + PART_W;
    localparam int DEPTH    = CELLS * PARTICLES_PER_CELL;
    localparam int WAVE_W   = 8;
    localparam int ENTRY_W  = $clog2(WAVE_LIMIT + 1);
    localparam int SWEEP_W  = ADDR_W - 1;

    // port field widths
    localparam int CFG_W     = 7;
    localparam int CELL_IN_W = 8;
    localparam int IDX_W     = 6;
    localparam int STATUS_W  = 2;

    // request modes
    typedef enum logic {
        MODE_PUSH  = 1'b0,
        MODE_CLEAR = 1'b1
    } mode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CELL  = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

    localparam logic [CFG_W-1:0] CELLS_IN_USE_RESET = CFG_W'(64);

endpackage : pws_pkg
`default_nettype wire

@@ hdl/pws_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pws_ram
// Generic dual-port synchronous RAM, each port writes when enabled and
// always reads; read data is registered.
// ----------------------------------------------------------------------------
module pws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     a_we,
    input  wire logic [$clog2(DEPTH)-1:0] a_addr,
    input  wire logic [WIDTH-1:0]         a_wdata,
    output logic      [WIDTH-1:0]         a_rdata,
    input  wire logic                     b_we,
    input  wire logic [$clog2(DEPTH)-1:0] b_addr,
    input  wire logic [WIDTH-1:0]         b_wdata,
    output logic      [WIDTH-1:0]         b_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // both ports, write and registered read
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem[a_addr] <= a_wdata;
        end
        if (b_we)
        begin
            mem[b_addr] <= b_wdata;
        end
        a_rdata <= mem[a_addr];
        b_rdata <= mem[b_addr];
    end

endmodule : pws_ram
`default_nettype wire

@@ hdl/pair_wave_scheduler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pair_wave_scheduler
// Assigns particle pairs of a cell to conflict-free waves using a per
// particle next-wave table held in a dual-port RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready): mode, cell_req, first_index, second_index.
//   out channel (out_valid/out_ready): status, out_cell, low_particle,
//   high_particle, wave; exactly one result transaction per input transaction.
//   cfg_we/cfg_wdata write cells_in_use; the user must write it only while
//   idle, as the block itself does not enforce this.
// Timing:
//   a push reads both entries at the accept edge; the next edge writes
//   wave+1 (held at the wave limit) to both entries of a valid pair and
//   loads the result register, with in_ready low in between. A clear
//   returns its result at once and sweeps the table, two entries per cycle.
// Reset:
//   the same sweep zeroes the table; no transaction is taken until a
//   sweep ends. cells_in_use resets to 64.
// Stall:
//   the result register holds until out_ready; a new transaction is taken
//   only when the result register is empty or drains in the same cycle.
// ----------------------------------------------------------------------------
module pair_wave_scheduler
    import pws_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // request channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 mode,
    input  wire logic [CELL_IN_W-1:0] cell_req,
    input  wire logic [IDX_W-1:0]     first_index,
    input  wire logic [IDX_W-1:0]     second_index,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [STATUS_W-1:0]       status,
    output logic [CELL_IN_W-1:0]      out_cell,
    output logic [IDX_W-1:0]          low_particle,
    output logic [IDX_W-1:0]          high_particle,
    output logic [WAVE_W-1:0]         wave
);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_UPDATE
    } state_t;

    state_t               state_reg;
    logic [SWEEP_W-1:0]   sweep_reg;
    logic [CFG_W-1:0]     cells_in_use_reg;

    // transaction captured at accept
    logic [CELL_IN_W-1:0] cell_reg;
    logic [IDX_W-1:0]     lo_reg;
    logic [IDX_W-1:0]     hi_reg;
    logic [ADDR_W-1:0]    addr_a_reg;
    logic [ADDR_W-1:0]    addr_b_reg;
    logic                 bad_reg;

    // result register
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [CELL_IN_W-1:0] out_cell_reg;
    logic [IDX_W-1:0]     low_reg;
    logic [IDX_W-1:0]     high_reg;
    logic [WAVE_W-1:0]    wave_reg;

    logic                 accept;
    logic                 load_result;
    logic [IDX_W-1:0]     lo_in;
    logic [IDX_W-1:0]     hi_in;
    logic [8:0]           limit_cells;
    logic                 bad_in;
    logic [ADDR_W-1:0]    addr_a_in;
    logic [ADDR_W-1:0]    addr_b_in;

    logic                 ram_a_we;
    logic                 ram_b_we;
    logic [ADDR_W-1:0]    ram_a_addr;
    logic [ADDR_W-1:0]    ram_b_addr;
    logic [ENTRY_W-1:0]   ram_a_wdata;
    logic [ENTRY_W-1:0]   ram_b_wdata;
    logic [ENTRY_W-1:0]   ram_a_rdata;
    logic [ENTRY_W-1:0]   ram_b_rdata;

    logic [ENTRY_W-1:0]   max_entry;
    logic                 saturated;
    logic [ENTRY_W-1:0]   next_entry;

    // handshake
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // result register loads on a clear accept or at the end of an update
    assign load_result = (state_reg == S_UPDATE) || (accept && (mode == MODE_CLEAR));

    // request decode: ordering, cell check and table addresses
    always_comb
    begin
        lo_in       = (first_index < second_index) ? first_index : second_index;
        hi_in       = (first_index < second_index) ? second_index : first_index;
        limit_cells = (9'(cells_in_use_reg) < 9'(CELLS)) ? 9'(cells_in_use_reg)
                                                          : 9'(CELLS);
        bad_in      = (9'(cell_req) >= limit_cells)
                      || (32'(hi_in) >= 32'(PARTICLES_PER_CELL));
        addr_a_in   = {cell_req[CELL_W-1:0], first_index[PART_W-1:0]};
        addr_b_in   = {cell_req[CELL_W-1:0], second_index[PART_W-1:0]};
    end

    // wave selection from the two read entries
    always_comb
    begin
        max_entry  = (ram_b_rdata > ram_a_rdata) ? ram_b_rdata : ram_a_rdata;
        saturated  = (32'(max_entry) >= 32'(WAVE_LIMIT));
        next_entry = saturated ? ENTRY_W'(WAVE_LIMIT) : max_entry + 1'b1;
    end

    // ram port steering: sweep, read at accept, write back in update
    always_comb
    begin
        ram_a_we    = 1'b0;
        ram_b_we    = 1'b0;
        ram_a_addr  = addr_a_in;
        ram_b_addr  = addr_b_in;
        ram_a_wdata = next_entry;
        ram_b_wdata = next_entry;
        case (state_reg)
            S_SWEEP:
            begin
                ram_a_we    = 1'b1;
                ram_b_we    = 1'b1;
                ram_a_addr  = {sweep_reg, 1'b0};
                ram_b_addr  = {sweep_reg, 1'b1};
                ram_a_wdata = '0;
                ram_b_wdata = '0;
            end
            S_UPDATE:
            begin
                ram_a_addr = addr_a_reg;
                ram_b_addr = addr_b_reg;
                ram_a_we   = !bad_reg;
                // same particle twice: one port writes the entry
                ram_b_we   = !bad_reg && (addr_b_reg != addr_a_reg);
            end
            default:
            begin
                ram_a_we = 1'b0;
                ram_b_we = 1'b0;
            end
        endcase
    end

    pws_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .a_we    (ram_a_we),
        .a_addr  (ram_a_addr),
        .a_wdata (ram_a_wdata),
        .a_rdata (ram_a_rdata),
        .b_we    (ram_b_we),
        .b_addr  (ram_b_addr),
        .b_wdata (ram_b_wdata),
        .b_rdata (ram_b_rdata)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_in_use_reg <= CELLS_IN_USE_RESET;
        end
        else if (cfg_we)
        begin
            cells_in_use_reg <= cfg_wdata;
        end
    end

    // capture of the accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_reg   <= cell_req;
            lo_reg     <= lo_in;
            hi_reg     <= hi_in;
            addr_a_reg <= addr_a_in;
            addr_b_reg <= addr_b_in;
            bad_reg    <= bad_in;
        end
    end

    // state machine and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            out_cell_reg  <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            wave_reg      <= '0;
        end
        else
        begin
            if (load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_SWEEP:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (mode == MODE_CLEAR)
                        begin
                            status_reg    <= ST_OK;
                            out_cell_reg  <= '0;
                            low_reg       <= '0;
                            high_reg      <= '0;
                            wave_reg      <= '0;
                            sweep_reg     <= '0;
                            state_reg     <= S_SWEEP;
                        end
                        else
                        begin
                            state_reg <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE:
                begin
                    out_cell_reg  <= cell_reg;
                    low_reg       <= lo_reg;
                    high_reg      <= hi_reg;
                    if (bad_reg)
                    begin
                        status_reg <= ST_BAD_CELL;
                        wave_reg   <= '0;
                    end
                    else
                    begin
                        status_reg <= saturated ? ST_SATURATED : ST_OK;
                        wave_reg   <= WAVE_W'(max_entry);
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // outputs
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_cell      = out_cell_reg;
    assign low_particle  = low_reg;
    assign high_particle = high_reg;
    assign wave          = wave_reg;

endmodule : pair_wave_scheduler
`default_nettype wire

@@ sim/pws_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pws_checker
// Watches the register, request and result ports of the pair wave scheduler.
// Keeps its own next-wave table and cells_in_use copy, predicts each result
// transaction when its request is accepted, and checks results in order.
// ----------------------------------------------------------------------------
module pws_checker
    import pws_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic                 mode,
    input  wire logic [CELL_IN_W-1:0] cell_req,
    input  wire logic [IDX_W-1:0]     first_index,
    input  wire logic [IDX_W-1:0]     second_index,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic [STATUS_W-1:0]  status,
    input  wire logic [CELL_IN_W-1:0] out_cell,
    input  wire logic [IDX_W-1:0]     low_particle,
    input  wire logic [IDX_W-1:0]     high_particle,
    input  wire logic [WAVE_W-1:0]    wave,
    output int                        fail_count,
    output int                        outstanding
);

    typedef struct packed {
        status_t               status;
        logic [CELL_IN_W-1:0]  cell_id;
        logic [IDX_W-1:0]      lo;
        logic [IDX_W-1:0]      hi;
        logic [WAVE_W-1:0]     wave;
    } wave_result_t;

    logic [ENTRY_W-1:0] next_wave [DEPTH];
    logic [CFG_W-1:0]   cells_cfg;
    wave_result_t       pending_waves [$];
    wave_result_t       want_res;

    // schedule one request against the local table and return its result
    function automatic wave_result_t predict_wave(input logic m,
                                                  input logic [CELL_IN_W-1:0] c,
                                                  input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        wave_result_t r;
        int limit_cells;
        int ia;
        int ib;
        int w;
        int nxt;
        r = '0;
        // clear wipes the table, result is all zero with ok status
        if (m == MODE_CLEAR)
        begin
            foreach (next_wave[i])
                next_wave[i] = '0;
            r.status = ST_OK;
            return r;
        end
        r.cell_id = c;
        r.lo      = (a < b) ? a : b;
        r.hi      = (a < b) ? b : a;
        // register above the table size acts as the table size
        limit_cells = (int'(cells_cfg) < CELLS) ? int'(cells_cfg) : CELLS;
        if (int'(c) >= limit_cells || int'(r.hi) >= PARTICLES_PER_CELL)
        begin
            r.status = ST_BAD_CELL;
            return r;
        end
        ia = int'(c) * PARTICLES_PER_CELL + int'(a);
        ib = int'(c) * PARTICLES_PER_CELL + int'(b);
        w  = (next_wave[ib] > next_wave[ia]) ? int'(next_wave[ib]) : int'(next_wave[ia]);
        // saturate at the wave limit
        if (w >= WAVE_LIMIT)
        begin
            w        = WAVE_LIMIT;
            nxt      = WAVE_LIMIT;
            r.status = ST_SATURATED;
        end
        else
        begin
            nxt      = w + 1;
            r.status = ST_OK;
        end
        next_wave[ia] = ENTRY_W'(nxt);
        next_wave[ib] = ENTRY_W'(nxt);
        r.wave        = WAVE_W'(w);
        return r;
    endfunction

    // one line per mismatch, all counted
    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // track register writes, predict on request, compare on result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (next_wave[i])
                next_wave[i] = '0;
            cells_cfg = CELLS_IN_USE_RESET;
            pending_waves.delete();
            outstanding = 0;
            fail_count  = 0;
        end
        else
        begin
            if (cfg_we)
                cells_cfg = cfg_wdata;

            // result transaction against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (pending_waves.size() == 0)
                    report_mismatch("result transaction with no request pending");
                else
                begin
                    want_res = pending_waves.pop_front();
                    check_field("status", int'(status), int'(want_res.status));
                    check_field("out_cell", int'(out_cell), int'(want_res.cell_id));
                    check_field("low_particle", int'(low_particle), int'(want_res.lo));
                    check_field("high_particle", int'(high_particle), int'(want_res.hi));
                    check_field("wave", int'(wave), int'(want_res.wave));
                end
            end

            // request transaction, appended at the tail of the queue
            if (in_valid && in_ready)
                pending_waves.insert(pending_waves.size(),
                                     predict_wave(mode, cell_req, first_index,
                                                  second_index));

            outstanding = pending_waves.size();
        end
    end

endmodule : pws_checker

@@ sim/pair_wave_scheduler_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pair_wave_scheduler_tb
// Drives the pair wave scheduler with directed pairs, a saturation run and
// random push/clear traffic under several cells_in_use settings, with random
// stalls on both channels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module pair_wave_scheduler_tb;
    import pws_pkg::*;

    localparam int HOLD_CYCLES = 200;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata    = '0;
    logic                 in_valid     = 1'b0;
    logic                 mode         = 1'b0;
    logic [CELL_IN_W-1:0] cell_req     = '0;
    logic [IDX_W-1:0]     first_index  = '0;
    logic [IDX_W-1:0]     second_index = '0;
    logic                 out_ready    = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic [STATUS_W-1:0]  status;
    logic [CELL_IN_W-1:0] out_cell;
    logic [IDX_W-1:0]     low_particle;
    logic [IDX_W-1:0]     high_particle;
    logic [WAVE_W-1:0]    wave;
    int                   fail_count;
    int                   outstanding;

    bit tx_gaps_on   = 1'b1;
    bit rx_gaps_on   = 1'b1;
    int hold_req_cnt = 0;

    // clock
    always #4 clk = ~clk;

    pair_wave_scheduler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .cell_req      (cell_req),
        .first_index   (first_index),
        .second_index  (second_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_cell      (out_cell),
        .low_particle  (low_particle),
        .high_particle (high_particle),
        .wave          (wave)
    );

    pws_checker u_pws_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .cell_req      (cell_req),
        .first_index   (first_index),
        .second_index  (second_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_cell      (out_cell),
        .low_particle  (low_particle),
        .high_particle (high_particle),
        .wave          (wave),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(8, 40));
        return int'($urandom_range(1, 3));
    endfunction

    // result side: random stalls plus a long hold on request
    initial
    begin
        int stall_left;
        int hold_done_cnt;
        stall_left    = 0;
        hold_done_cnt = 0;
        forever
        begin
            @(negedge clk);
            if (hold_done_cnt != hold_req_cnt)
            begin
                hold_done_cnt = hold_req_cnt;
                stall_left    = HOLD_CYCLES;
            end
            else if (stall_left == 0 && rx_gaps_on && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // offer one request transaction and wait until it is taken
    task automatic send_item(input logic m, input logic [CELL_IN_W-1:0] c,
                             input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        mode         <= m;
        cell_req     <= c;
        first_index  <= a;
        second_index <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // random request: mostly hot cells and particles so waves build up
    task automatic send_random(input int cells);
        logic                 m;
        logic [CELL_IN_W-1:0] c;
        logic [IDX_W-1:0]     a;
        logic [IDX_W-1:0]     b;
        m = ($urandom_range(0, 63) == 0);
        case ($urandom_range(0, 9))
            0, 1:    c = CELL_IN_W'($urandom_range(0, 255));
            2:       c = (cells == 0) ? '0 : CELL_IN_W'($urandom_range(cells - 1, cells));
            default: c = CELL_IN_W'($urandom_range(0, 3));
        endcase
        a = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 7))
                                       : IDX_W'($urandom_range(0, 63));
        b = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 7))
                                       : IDX_W'($urandom_range(0, 63));
        send_item(m, c, a, b);
    endtask

    // stop offering and wait for every predicted result
    task automatic wait_drained();
        @(negedge clk) in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // register write only once the block is idle
    task automatic set_cells_in_use(input logic [CFG_W-1:0] v);
        wait_drained();
        repeat (4) @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int cells, input int count);
        set_cells_in_use(CFG_W'(cells));
        repeat (count) send_random(cells);
    endtask

    // watchdog
    initial
    begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int mid_cells;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed: edges of cells and particles, same particle, bad cells
        send_item(MODE_PUSH, 8'd0, 6'd0, 6'd63);
        send_item(MODE_PUSH, 8'd0, 6'd63, 6'd0);
        send_item(MODE_PUSH, 8'd0, 6'd5, 6'd5);
        send_item(MODE_PUSH, 8'd0, 6'd5, 6'd5);
        send_item(MODE_PUSH, 8'd63, 6'd63, 6'd63);
        send_item(MODE_PUSH, 8'd63, 6'd0, 6'd63);
        send_item(MODE_PUSH, 8'd64, 6'd1, 6'd2);
        send_item(MODE_PUSH, 8'd255, 6'd63, 6'd0);
        send_item(MODE_PUSH, 8'd0, 6'd0, 6'd5);
        send_item(MODE_CLEAR, 8'd255, 6'd63, 6'd63);
        send_item(MODE_PUSH, 8'd0, 6'd0, 6'd63);
        // only cell zero valid
        set_cells_in_use(7'd1);
        send_item(MODE_PUSH, 8'd0, 6'd1, 6'd2);
        send_item(MODE_PUSH, 8'd1, 6'd1, 6'd2);
        // every cell rejected
        set_cells_in_use(7'd0);
        send_item(MODE_PUSH, 8'd0, 6'd1, 6'd2);
        // register above table size acts as table size
        set_cells_in_use(7'd127);
        send_item(MODE_PUSH, 8'd63, 6'd62, 6'd61);
        send_item(MODE_PUSH, 8'd64, 6'd0, 6'd0);
        send_item(MODE_PUSH, 8'd126, 6'd1, 6'd1);
        set_cells_in_use(7'd64);
        send_item(MODE_PUSH, 8'd63, 6'd61, 6'd62);
        send_item(MODE_PUSH, 8'd64, 6'd61, 6'd62);
        send_item(MODE_CLEAR, 8'd0, 6'd0, 6'd0);

        // long result hold while requests keep coming, then a full drain
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        set_cells_in_use(7'd64);
        hold_req_cnt++;
        repeat (125) send_random(64);
        wait_drained();
        repeat (125) send_random(64);

        // saturation run on one pair, then saturated entries mixed with fresh ones
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        send_item(MODE_CLEAR, 8'd0, 6'd0, 6'd0);
        repeat (258) send_item(MODE_PUSH, 8'd3, 6'd10, 6'd20);
        send_item(MODE_PUSH, 8'd3, 6'd20, 6'd21);
        send_item(MODE_PUSH, 8'd3, 6'd21, 6'd21);
        send_item(MODE_PUSH, 8'd3, 6'd22, 6'd22);

        // random phases over several register settings
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        run_random(127, 250);
        tx_gaps_on = 1'b0;
        run_random(1, 100);
        run_random(0, 30);
        tx_gaps_on = 1'b1;
        repeat (2)
        begin
            mid_cells = int'($urandom_range(2, 126));
            run_random(mid_cells, 150);
        end
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_random(64, 150);

        // drain and let the pipeline settle
        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule : pair_wave_scheduler_tb
